// ===== rtl/rrts_pkg.sv =====
// rrts_pkg: shared types and constants for the round-robin task scheduler.
// Holds command, task-state, status and sequencer codes plus field widths.
// No dependencies.
package rrts_pkg;

   localparam int TGT_W      = 7;
   localparam int HANDLE_W   = 7;
   localparam int CHAR_W     = 9;
   localparam int TIME_W     = 32;
   localparam int CMD_W      = 3;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 3'd0,
      CMD_EXIT   = 3'd1,
      CMD_WAIT   = 3'd2,
      CMD_SLEEP  = 3'd3,
      CMD_RCHAR  = 3'd4,
      CMD_POLL   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_UNUSED = 3'd0,
      ST_READY  = 3'd1,
      ST_SLEEP  = 3'd2,
      ST_WTASK  = 3'd3,
      ST_RUN    = 3'd4,
      ST_EXITED = 3'd5,
      ST_WCHAR  = 3'd6
   } task_state_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_IDLE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_DECIDE,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

endpackage

// ===== rtl/round_robin_task_scheduler.sv =====
// round_robin_task_scheduler: hardware round-robin thread scheduler.
// Task table kept in on-chip memories, scanned by a small sequencer.
// Depends on rrts_pkg.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  req      | in        | req_tvalid/req_tready  | req_tuser command, req_tdata fields
//  rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata status and dispatch fields
//
// Create, poll-while-running and unused commands go from execute straight to done; the
// all-exited resume passes through decide; other commands scan from the entry after the
// running task until one is eligible or all are seen; one entry is issued per cycle.
// Reset (synchronous, active high) leaves task 0 running and one task in the table.
// A new request is taken while an earlier response still waits; the block holds
// in its final state until the response register is free.
module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int TASK_SLOTS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // target_task[6:0], sleep_ms[38:7], now_ms[70:39], char_valid[71], char_in[80:72]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[2:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], dispatched[2], next_task[9:3], new_handle[16:10],
   // char_taken[17], char_out[26:18]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (TASK_SLOTS > 2) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int CMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;

   // request latch
   cmd_type             cmd_ff;
   logic [TGT_W-1:0]    tgt_ff;
   logic [TIME_W-1:0]   sleep_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                cval_ff;
   logic [CHAR_W-1:0]   cin_ff;

   // control state
   fsm_type             fsm_ff, fsm_in;
   logic [IDX_W-1:0]    run_ff, run_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    exit_cnt_ff, exit_cnt_in;
   task_state_type      cur_st_ff, cur_st_in;
   logic                zero_wr_ff, zero_wr_in;
   logic [CNT_W-1:0]    iss_left_ff, iss_left_in;
   logic [IDX_W-1:0]    iss_idx_ff, iss_idx_in;
   logic                s1_vld_ff, s1_vld_in;
   logic                s2_vld_ff, s2_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // result being built
   status_type          res_status_ff, res_status_in;
   logic                res_disp_ff, res_disp_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                res_taken_ff, res_taken_in;
   logic [CHAR_W-1:0]   res_cout_ff, res_cout_in;

   // scan pipe
   logic [IDX_W-1:0]    s1_idx_ff, s2_idx_ff;
   task_state_type      s1_state_ff, s2_state_ff;
   logic                s1_zero_ff;
   logic [TIME_W-1:0]   s1_wake_ff, s2_wake_ff;
   logic [TGT_W-1:0]    s1_await_ff;
   task_state_type      s2_tstate_ff;
   logic                s2_tok_ff;

   // memories
   task_state_type      state_mem [TASK_SLOTS];
   logic [TIME_W-1:0]   wake_mem  [TASK_SLOTS];
   logic [TGT_W-1:0]    await_mem [TASK_SLOTS];

   logic                st_we;
   logic [IDX_W-1:0]    st_wa;
   task_state_type      st_wd;
   logic                wk_we;
   logic                aw_we;

   logic                req_acc;
   logic [TIME_W:0]     wake_sum;
   logic [TIME_W-1:0]   wake_sat;
   logic [IDX_W-1:0]    tgt_addr;
   logic                elig;
   logic                found;
   logic                issue;
   task_state_type      new_st;
   logic [CNT_W-1:0]    run_nxt;
   logic [CNT_W-1:0]    iss_nxt;

   assign req_tready = (fsm_ff == FSM_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign wake_sum = {1'b0, now_ff} + {1'b0, sleep_ff};
   assign wake_sat = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];
   assign tgt_addr = IDX_W'(CMP_W'(s1_await_ff));
   assign run_nxt  = CNT_W'(run_ff) + CNT_W'(1);
   assign iss_nxt  = CNT_W'(iss_idx_ff) + CNT_W'(1);

   always_comb begin
      case (s2_state_ff)
         ST_READY: elig = 1'b1;
         ST_SLEEP: elig = s2_wake_ff < now_ff;
         ST_WTASK: elig = s2_tok_ff && (s2_tstate_ff == ST_EXITED);
         ST_WCHAR: elig = cval_ff;
         default:  elig = 1'b0;
      endcase
   end

   assign found = (fsm_ff == FSM_SCAN) && s2_vld_ff && elig;
   assign issue = (fsm_ff == FSM_SCAN) && (iss_left_ff != '0) && !found;

   always_comb begin
      case (cmd_ff)
         CMD_EXIT:  new_st = ST_EXITED;
         CMD_WAIT:  new_st = ST_WTASK;
         CMD_SLEEP: new_st = ST_SLEEP;
         default:   new_st = ST_WCHAR;
      endcase
   end

   always_comb begin
      fsm_in        = fsm_ff;
      run_in        = run_ff;
      cnt_in        = cnt_ff;
      exit_cnt_in   = exit_cnt_ff;
      cur_st_in     = cur_st_ff;
      zero_wr_in    = zero_wr_ff;
      iss_left_in   = iss_left_ff;
      iss_idx_in    = iss_idx_ff;
      s1_vld_in     = 1'b0;
      s2_vld_in     = 1'b0;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      res_status_in = res_status_ff;
      res_disp_in   = res_disp_ff;
      res_handle_in = res_handle_ff;
      res_taken_in  = res_taken_ff;
      res_cout_in   = res_cout_ff;
      st_we         = 1'b0;
      st_wa         = run_ff;
      st_wd         = ST_RUN;
      wk_we         = 1'b0;
      aw_we         = 1'b0;

      unique case (fsm_ff)
         FSM_IDLE: begin
            if (req_tvalid) begin
               res_status_in = STAT_OK;
               res_disp_in   = 1'b0;
               res_handle_in = '0;
               res_taken_in  = 1'b0;
               res_cout_in   = '0;
               fsm_in        = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            case (cmd_ff) inside
               CMD_CREATE: begin
                  if (cnt_ff == CNT_W'(TASK_SLOTS)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     st_we         = 1'b1;
                     st_wa         = IDX_W'(cnt_ff);
                     st_wd         = ST_READY;
                     res_handle_in = HANDLE_W'(cnt_ff);
                     cnt_in        = cnt_ff + CNT_W'(1);
                  end
                  fsm_in = FSM_DONE;
               end
               CMD_EXIT, CMD_WAIT, CMD_SLEEP, CMD_RCHAR: begin
                  st_we     = 1'b1;
                  st_wa     = run_ff;
                  st_wd     = new_st;
                  cur_st_in = new_st;
                  wk_we     = (cmd_ff == CMD_SLEEP);
                  aw_we     = (cmd_ff == CMD_WAIT);
                  // exited count covers tasks 1 and up
                  if (run_ff == '0) begin
                     zero_wr_in = 1'b1;
                  end else if (new_st == ST_EXITED && cur_st_ff != ST_EXITED) begin
                     exit_cnt_in = exit_cnt_ff + CNT_W'(1);
                  end else if (new_st != ST_EXITED && cur_st_ff == ST_EXITED) begin
                     exit_cnt_in = exit_cnt_ff - CNT_W'(1);
                  end
                  fsm_in = FSM_DECIDE;
               end
               CMD_POLL: begin
                  fsm_in = (cur_st_ff == ST_RUN) ? FSM_DONE : FSM_DECIDE;
               end
               default: begin
                  fsm_in = FSM_DONE;
               end
            endcase
         end
         FSM_DECIDE: begin
            if (exit_cnt_ff == cnt_ff - CNT_W'(1)) begin
               // every other task gone: resume task 0
               st_we       = 1'b1;
               st_wa       = '0;
               st_wd       = ST_RUN;
               zero_wr_in  = 1'b1;
               run_in      = '0;
               cur_st_in   = ST_RUN;
               res_disp_in = 1'b1;
               fsm_in      = FSM_DONE;
            end else begin
               iss_idx_in  = (run_nxt == cnt_ff) ? '0 : IDX_W'(run_nxt);
               iss_left_in = cnt_ff;
               fsm_in      = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            s1_vld_in = issue;
            s2_vld_in = s1_vld_ff && !found;
            if (issue) begin
               iss_left_in = iss_left_ff - CNT_W'(1);
               iss_idx_in  = (iss_nxt == cnt_ff) ? '0 : IDX_W'(iss_nxt);
            end
            if (found) begin
               st_we        = 1'b1;
               st_wa        = s2_idx_ff;
               st_wd        = ST_RUN;
               run_in       = s2_idx_ff;
               cur_st_in    = ST_RUN;
               res_disp_in  = 1'b1;
               res_taken_in = (s2_state_ff == ST_WCHAR);
               res_cout_in  = (s2_state_ff == ST_WCHAR) ? cin_ff : '0;
               if (s2_idx_ff == '0) begin
                  zero_wr_in = 1'b1;
               end
               fsm_in = FSM_DONE;
            end else if (iss_left_ff == '0 && !s1_vld_ff && !s2_vld_ff) begin
               res_status_in = STAT_IDLE;
               fsm_in        = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {5'b0, res_cout_ff, res_taken_ff, res_handle_ff,
                              HANDLE_W'(run_ff), res_disp_ff, res_status_ff};
               fsm_in      = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff      <= FSM_IDLE;
         run_ff      <= '0;
         cnt_ff      <= CNT_W'(1);
         exit_cnt_ff <= '0;
         cur_st_ff   <= ST_RUN;
         zero_wr_ff  <= 1'b0;
         iss_left_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         fsm_ff      <= fsm_in;
         run_ff      <= run_in;
         cnt_ff      <= cnt_in;
         exit_cnt_ff <= exit_cnt_in;
         cur_st_ff   <= cur_st_in;
         zero_wr_ff  <= zero_wr_in;
         iss_left_ff <= iss_left_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff   <= cmd_type'(req_tuser);
         tgt_ff   <= req_tdata[6:0];
         sleep_ff <= req_tdata[38:7];
         now_ff   <= req_tdata[70:39];
         cval_ff  <= req_tdata[71];
         cin_ff   <= req_tdata[80:72];
      end
      iss_idx_ff    <= iss_idx_in;
      rsp_data_ff   <= rsp_data_in;
      res_status_ff <= res_status_in;
      res_disp_ff   <= res_disp_in;
      res_handle_ff <= res_handle_in;
      res_taken_ff  <= res_taken_in;
      res_cout_ff   <= res_cout_in;

      // stage 1 side info; stage 2 resolves the unwritten task 0 entry
      s1_idx_ff   <= iss_idx_ff;
      s1_zero_ff  <= (iss_idx_ff == '0) && !zero_wr_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_state_ff <= s1_zero_ff ? ST_RUN : s1_state_ff;
      s2_wake_ff  <= s1_wake_ff;
      // slots at or past the count were never created and read as unused
      s2_tok_ff   <= (CMP_W'(s1_await_ff) < CMP_W'(cnt_ff)) &&
                     !((tgt_addr == '0) && !zero_wr_ff);
   end

   // task state memory: one write port, scan read and awaited-task read
   always_ff @(posedge clock) begin
      if (st_we) begin
         state_mem[st_wa] <= st_wd;
      end
      s1_state_ff  <= state_mem[iss_idx_ff];
      s2_tstate_ff <= state_mem[tgt_addr];
   end

   always_ff @(posedge clock) begin
      if (wk_we) begin
         wake_mem[run_ff] <= wake_sat;
      end
      s1_wake_ff <= wake_mem[iss_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (aw_we) begin
         await_mem[run_ff] <= tgt_ff;
      end
      s1_await_ff <= await_mem[iss_idx_ff];
   end

   // checks
   a_run_in_table: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(run_ff) < cnt_ff)
      else $error("running task outside the task table");

   a_exit_cnt: assert property (@(posedge clock) disable iff (reset)
      exit_cnt_ff < cnt_ff)
      else $error("exited count exceeds task count");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff || s2_vld_ff) |-> (fsm_ff == FSM_SCAN))
      else $error("scan pipe busy outside scan");

   a_disp_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_data_ff[2]) |-> (rsp_data_ff[1:0] == STAT_OK))
      else $error("dispatch with non-ok status");

   a_taken_disp: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_data_ff[17]) |-> rsp_data_ff[2])
      else $error("character taken without dispatch");

endmodule

// ===== sim/tb_round_robin_task_scheduler.sv =====
// tb_round_robin_task_scheduler: self-checking bench for the round-robin task scheduler.
// Predicts every response from its own copy of the task table; random idling on both sides.
// Depends on rrts_pkg and round_robin_task_scheduler.
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
   import rrts_pkg::*;

   localparam int NUM_SLOTS  = 128;
   localparam int LONG_HOLD  = 300;
   localparam int SETTLE     = 160;

   // fields of one request, target_task in the lowest bits
   typedef struct packed {
      logic [CHAR_W-1:0]   char_in;
      logic                char_valid;
      logic [TIME_W-1:0]   now_ms;
      logic [TIME_W-1:0]   sleep_ms;
      logic [TGT_W-1:0]    target_task;
   } sched_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_out;
      logic                char_taken;
      logic [HANDLE_W-1:0] new_handle;
      logic [TGT_W-1:0]    next_task;
      logic                dispatched;
      status_type          status;
   } sched_rsp_type;

   localparam int REQ_BITS = $bits(sched_req_type);
   localparam int RSP_BITS = $bits(sched_rsp_type);

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // scheduler state as the bench sees it
   task_state_type        slot_state   [NUM_SLOTS];
   logic [TIME_W-1:0]     slot_wake    [NUM_SLOTS];
   logic [TGT_W-1:0]      slot_awaited [NUM_SLOTS];
   logic [CHAR_W-1:0]     slot_char    [NUM_SLOTS];
   logic [TGT_W-1:0]      run_task;
   int unsigned           task_total;

   sched_rsp_type         dispatch_q [$];

   int unsigned           mismatch_count;
   int unsigned           cmds_sent;
   int unsigned           rsps_checked;
   int unsigned           idle_seen;
   int unsigned           full_seen;
   int unsigned           chars_seen;
   int unsigned           tasks_made = 1;
   logic [TIME_W-1:0]     sim_ms     = 32'd1000;
   bit                    req_no_gaps;
   bit                    rsp_no_stalls;
   bit                    rsp_hold_req;
   int unsigned           rsp_hold_left;
   int unsigned           rsp_stall_left;

   round_robin_task_scheduler #(.TASK_SLOTS(NUM_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("%0t: timeout, %0d responses still outstanding", $time, dispatch_q.size());
      $display("tb_round_robin_task_scheduler: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_task_table();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_state[i]   = ST_UNUSED;
         slot_wake[i]    = '0;
         slot_awaited[i] = '0;
         slot_char[i]    = '0;
      end
      slot_state[0] = ST_RUN;
      run_task      = '0;
      task_total    = 1;
   endfunction

   function automatic bit can_run(int unsigned idx, logic [TIME_W-1:0] now, logic cvalid);
      case (slot_state[idx])
         ST_READY: return 1'b1;
         ST_SLEEP: return slot_wake[idx] < now;
         ST_WTASK: return slot_state[slot_awaited[idx]] == ST_EXITED;
         ST_WCHAR: return cvalid;
         default:  return 1'b0;
      endcase
   endfunction

   function automatic sched_rsp_type schedule_command(cmd_type cmd, sched_req_type r);
      sched_rsp_type  o;
      logic [TGT_W-1:0] cur;
      logic [TIME_W:0]  wsum;
      bit             scan;
      bit             all_gone;
      bit             found;
      int unsigned    idx;
      o    = '0;
      cur  = run_task;
      scan = 1'b0;
      case (cmd)
         CMD_CREATE: begin
            if (task_total >= NUM_SLOTS) begin
               o.status = STAT_FULL;
            end else begin
               o.new_handle           = task_total[HANDLE_W-1:0];
               slot_state[task_total] = ST_READY;
               task_total++;
            end
         end
         CMD_EXIT: begin
            slot_state[cur] = ST_EXITED;
            scan = 1'b1;
         end
         CMD_WAIT: begin
            slot_awaited[cur] = r.target_task;
            slot_state[cur]   = ST_WTASK;
            scan = 1'b1;
         end
         CMD_SLEEP: begin
            wsum = {1'b0, r.now_ms} + {1'b0, r.sleep_ms};
            slot_wake[cur]  = wsum[TIME_W] ? '1 : wsum[TIME_W-1:0];
            slot_state[cur] = ST_SLEEP;
            scan = 1'b1;
         end
         CMD_RCHAR: begin
            slot_state[cur] = ST_WCHAR;
            scan = 1'b1;
         end
         CMD_POLL: scan = slot_state[cur] != ST_RUN;
         default: ;
      endcase
      if (scan) begin
         all_gone = 1'b1;
         for (int i = 1; i < task_total; i++)
            if (slot_state[i] != ST_EXITED) all_gone = 1'b0;
         if (all_gone) begin
            // nobody else left: task 0 resumes whatever it was doing
            run_task      = '0;
            slot_state[0] = ST_RUN;
            o.dispatched  = 1'b1;
         end else begin
            found = 1'b0;
            for (int k = 1; k <= task_total; k++) begin
               idx = (int'(cur) + k) % task_total;
               if (!found && can_run(idx, r.now_ms, r.char_valid)) begin
                  found = 1'b1;
                  if (slot_state[idx] == ST_WCHAR) begin
                     slot_char[idx] = r.char_in;
                     o.char_taken   = 1'b1;
                     o.char_out     = r.char_in;
                  end
                  slot_state[idx] = ST_RUN;
                  run_task        = idx[TGT_W-1:0];
               end
            end
            if (found) o.dispatched = 1'b1;
            else o.status = STAT_IDLE;
         end
      end
      o.next_task = run_task;
      return o;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // responses are popped before the request of the same edge is predicted
   always @(posedge clock) begin
      sched_rsp_type got;
      sched_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            rsps_checked++;
            if (got.status == STAT_IDLE) idle_seen++;
            if (got.status == STAT_FULL) full_seen++;
            if (got.char_taken) chars_seen++;
            if (dispatch_q.size() == 0) begin
               $display("%0t: response with nothing expected, expected none, actual %h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = dispatch_q.pop_front();
               check_field("status", int'(want.status), int'(got.status));
               check_field("dispatched", int'(want.dispatched), int'(got.dispatched));
               check_field("next_task", int'(want.next_task), int'(got.next_task));
               check_field("new_handle", int'(want.new_handle), int'(got.new_handle));
               check_field("char_taken", int'(want.char_taken), int'(got.char_taken));
               check_field("char_out", int'(want.char_out), int'(got.char_out));
            end
         end
         if (req_tvalid && req_tready)
            dispatch_q.push_back(schedule_command(cmd_type'(req_tuser),
                                                  req_tdata[REQ_BITS-1:0]));
      end
   end

   // ---------------------------------------------------------------- both sides

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (rsp_hold_req) begin
         rsp_hold_req  = 1'b0;
         rsp_hold_left = LONG_HOLD;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_no_stalls) rsp_stall_left = pick_gap();
      end
   end

   task automatic send_command(input cmd_type cmd, input sched_req_type r);
      int unsigned gap;
      gap = req_no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'(r);
      do @(posedge clock); while (!req_tready);
      cmds_sent++;
      if (cmd == CMD_CREATE) tasks_made++;
   endtask

   task automatic issue(input cmd_type cmd, input logic [TGT_W-1:0] tgt,
                        input logic [TIME_W-1:0] ms, input logic [TIME_W-1:0] now,
                        input logic cvalid, input logic [CHAR_W-1:0] cin);
      sched_req_type r;
      r.target_task = tgt;
      r.sleep_ms    = ms;
      r.now_ms      = now;
      r.char_valid  = cvalid;
      r.char_in     = cin;
      send_command(cmd, r);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (dispatch_q.size() != 0) @(posedge clock);
   endtask

   // mostly a slowly advancing clock, now and then any 32-bit value
   function automatic sched_req_type random_fields();
      sched_req_type r;
      int unsigned   roll;
      sim_ms = sim_ms + $urandom_range(12);
      r.now_ms = ($urandom_range(99) < 3) ? $urandom() : sim_ms;
      roll = $urandom_range(99);
      if (roll < 80) r.sleep_ms = $urandom_range(40);
      else if (roll < 92) r.sleep_ms = $urandom_range(400);
      else r.sleep_ms = $urandom();
      if ($urandom_range(99) < 75)
         r.target_task = TGT_W'($urandom_range(tasks_made > NUM_SLOTS ? NUM_SLOTS - 1
                                                                      : tasks_made - 1));
      else
         r.target_task = TGT_W'($urandom_range(NUM_SLOTS - 1));
      r.char_valid = $urandom_range(99) < 40;
      r.char_in    = CHAR_W'($urandom_range(511));
      return r;
   endfunction

   task automatic send_random_command(input int unsigned task_cap);
      cmd_type     cmd;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) cmd = CMD_CREATE;
      else if (roll < 13) cmd = CMD_EXIT;
      else if (roll < 30) cmd = CMD_WAIT;
      else if (roll < 55) cmd = CMD_SLEEP;
      else if (roll < 75) cmd = CMD_RCHAR;
      else cmd = CMD_POLL;
      if (cmd == CMD_CREATE && tasks_made >= task_cap) cmd = CMD_POLL;
      send_command(cmd, random_fields());
   endtask

   // ---------------------------------------------------------------- tests

   // lone task, saturated wake time, strict wake compare, char handoff,
   // waiting on an unused slot, idle and retry, and the all-exited resume
   task automatic test_directed_cases();
      issue(CMD_POLL,   7'd0,   32'd0,        32'd0,        1'b0, 9'd0);
      issue(CMD_RCHAR,  7'd0,   32'd0,        32'd5,        1'b1, 9'h1AA);
      issue(CMD_EXIT,   7'd0,   32'd0,        32'd6,        1'b0, 9'd0);
      issue(CMD_CREATE, 7'd127, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 9'h1FF);
      issue(CMD_CREATE, 7'd0,   32'd0,        32'd0,        1'b0, 9'd0);
      issue(CMD_CREATE, 7'h55,  32'h5555AAAA, 32'hAAAA5555, 1'b0, 9'h0AA);
      issue(CMD_SLEEP,  7'd0,   32'hFFFFFFFF, 32'hFFFFFFF0, 1'b0, 9'd0);
      issue(CMD_RCHAR,  7'd0,   32'd0,        32'hFFFFFFF8, 1'b0, 9'h155);
      issue(CMD_WAIT,   7'd3,   32'd0,        32'hFFFFFFF9, 1'b0, 9'd0);
      issue(CMD_EXIT,   7'd0,   32'd0,        32'hFFFFFFFF, 1'b1, 9'h1FF);
      issue(CMD_WAIT,   7'd2,   32'd0,        32'd0,        1'b1, 9'd0);
      issue(CMD_EXIT,   7'd0,   32'd0,        32'd1,        1'b0, 9'd0);
      issue(CMD_WAIT,   7'd4,   32'd0,        32'd2,        1'b0, 9'd0);
      issue(CMD_POLL,   7'd0,   32'd0,        32'h12345678, 1'b1, 9'h0AA);
      issue(CMD_CREATE, 7'd0,   32'd0,        32'd40,       1'b0, 9'd0);
      issue(CMD_POLL,   7'd0,   32'd0,        32'd50,       1'b0, 9'd0);
      issue(CMD_SLEEP,  7'd0,   32'd0,        32'd100,      1'b0, 9'd0);
      issue(CMD_POLL,   7'd0,   32'd0,        32'd100,      1'b0, 9'd0);
      issue(CMD_POLL,   7'd0,   32'd0,        32'd101,      1'b0, 9'd0);
      issue(CMD_EXIT,   7'd0,   32'd0,        32'd102,      1'b0, 9'd0);
      issue(CMD_EXIT,   7'd0,   32'd0,        32'd103,      1'b1, 9'h001);
      issue(CMD_POLL,   7'd0,   32'd0,        32'd104,      1'b0, 9'd0);
      issue(CMD_CREATE, 7'd0,   32'd0,        32'd105,      1'b0, 9'd0);
      wait_for_results();
   endtask

   task automatic test_random_mix();
      repeat (450) send_random_command(48);
      wait_for_results();
   endtask

   // receiver holds off long enough that the block backs up into the input
   task automatic test_output_backpressure();
      req_no_gaps  = 1'b1;
      rsp_hold_req = 1'b1;
      repeat (20) send_random_command(48);
      req_no_gaps  = 1'b0;
      wait_for_results();
   endtask

   task automatic test_back_to_back();
      req_no_gaps   = 1'b1;
      rsp_no_stalls = 1'b1;
      repeat (150) send_random_command(64);
      req_no_gaps   = 1'b0;
      rsp_no_stalls = 1'b0;
      wait_for_results();
   endtask

   task automatic test_table_full();
      while (tasks_made < NUM_SLOTS + 4) send_command(CMD_CREATE, random_fields());
      wait_for_results();
   endtask

   task automatic test_random_full_table();
      repeat (250) send_random_command(NUM_SLOTS + 100);
      wait_for_results();
   endtask

   initial begin
      clear_task_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_mix();
      test_output_backpressure();
      test_back_to_back();
      test_table_full();
      test_random_full_table();
      repeat (SETTLE) @(posedge clock);
      if (dispatch_q.size() != 0) begin
         $display("%0t: %0d responses never arrived, expected 0, actual %0d",
                  $time, dispatch_q.size(), dispatch_q.size());
         mismatch_count++;
      end
      $display("%0d commands in, %0d responses checked, table grown to %0d tasks",
               cmds_sent, rsps_checked, task_total);
      $display("%0d idle scans, %0d creates refused on a full table, %0d chars handed over",
               idle_seen, full_seen, chars_seen);
      if (mismatch_count == 0)
         $display("tb_round_robin_task_scheduler: done, clean");
      else
         $display("tb_round_robin_task_scheduler: done, errors");
      $finish;
   end

endmodule
